/* hdl/scie_pkg.sv */
// package for the small cpu instruction execute block
// types, codes and constants shared by all modules but scie_ram; no dependencies
`timescale 1ns / 1ps

package scie_pkg;

  localparam int PC_W = 10;
  localparam int PLEN_W = 11;
  localparam int LCNT_W = 7;
  localparam int WORD_W = 32;
  localparam int FIELD_REG_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int IN_TDATA_W = 56;
  localparam int OUT_TDATA_W = 48;

  localparam int DATA_WORDS_DEF = 1024;
  localparam int MAX_LABELS_DEF = 64;
  localparam int NUM_REGS_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LABEL_COUNT = 2'd1;

  localparam logic [WORD_W-1:0] FLAGS_EQ = 32'd1;
  localparam logic [WORD_W-1:0] FLAGS_GT = 32'd2;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_MOVE = 5'd1, OP_LOAD = 5'd2, OP_STORE = 5'd3,
    OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7,
    OP_MOD = 5'd8, OP_AND = 5'd9, OP_OR = 5'd10, OP_XOR = 5'd11,
    OP_NOT = 5'd12, OP_SHL = 5'd13, OP_SHR = 5'd14, OP_CMP = 5'd15,
    OP_JMP = 5'd16, OP_JZ = 5'd17, OP_JNZ = 5'd18, OP_JG = 5'd19,
    OP_JL = 5'd20, OP_PUSH = 5'd21, OP_POP = 5'd22, OP_CALL = 5'd23,
    OP_RET = 5'd24, OP_PRINT = 5'd25, OP_HALT = 5'd26
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_OPER, ST_EXEC, ST_DIV, ST_DWB
  } st_t;

  typedef struct packed {
    logic                   is_label;
    op_t                    op;
    logic                   has_dst;
    logic                   has_src;
    logic                   uses_label;
    logic [FIELD_REG_W-1:0] dst;
    logic [FIELD_REG_W-1:0] src;
    logic [WORD_W-1:0]      imm;
    logic [PC_W-1:0]        tgt;
  } item_t;

endpackage

/* hdl/scie_ram.sv */
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module scie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/scie_queue.sv */
// two entry queue of classified requests between front and back
// depends on scie_pkg
`timescale 1ns / 1ps

module scie_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  scie_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output scie_pkg::item_t out_item
);

  scie_pkg::item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item = slot[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

endmodule

/* hdl/scie_front.sv */
// front end: takes requests from the input stream and classifies them
// depends on scie_pkg
`timescale 1ns / 1ps

module scie_front #(
  parameter int NUM_REGS = scie_pkg::NUM_REGS_DEF
) (
  input  logic                               blocked,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [scie_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tuser,
  output logic                               q_valid,
  input  logic                               q_ready,
  output scie_pkg::item_t                    q_item
);

  logic [scie_pkg::FIELD_REG_W-1:0] dst;
  logic [scie_pkg::FIELD_REG_W-1:0] src;
  logic [4:0]                       opc;

  assign opc = s_axis_tdata[4:0];
  assign dst = s_axis_tdata[8:5];
  assign src = s_axis_tdata[12:9];

  assign s_axis_tready = q_ready && !blocked;
  assign q_valid = s_axis_tvalid && !blocked;

  always_comb begin
    q_item.is_label = s_axis_tuser;
    q_item.op = scie_pkg::op_t'(opc);
    q_item.has_dst = ({2'b00, dst} < 6'(NUM_REGS));
    q_item.has_src = ({2'b00, src} < 6'(NUM_REGS));
    q_item.dst = dst;
    q_item.src = src;
    q_item.imm = s_axis_tdata[44:13];
    q_item.tgt = s_axis_tdata[54:45];
    unique case (scie_pkg::op_t'(opc)) inside
      scie_pkg::OP_JMP, scie_pkg::OP_JZ, scie_pkg::OP_JNZ, scie_pkg::OP_JG,
      scie_pkg::OP_JL, scie_pkg::OP_CALL: q_item.uses_label = 1'b1;
      default: q_item.uses_label = 1'b0;
    endcase
  end

endmodule

/* hdl/scie_div.sv */
// unsigned 32 bit divider, one quotient bit per cycle
// depends on scie_pkg
`timescale 1ns / 1ps

module scie_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [scie_pkg::WORD_W-1:0] dividend,
  input  logic [scie_pkg::WORD_W-1:0] divisor,
  output logic                        done,
  output logic [scie_pkg::WORD_W-1:0] quot,
  output logic [scie_pkg::WORD_W-1:0] rem
);

  logic [5:0]                  cnt;
  logic                        busy;
  logic [scie_pkg::WORD_W-1:0] dv;
  logic [scie_pkg::WORD_W:0]   trial;
  logic [scie_pkg::WORD_W:0]   diff;

  assign trial = {rem, quot[scie_pkg::WORD_W-1]};
  assign diff = trial - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem <= '0;
      dv <= divisor;
    end else if (busy) begin
      if (!diff[scie_pkg::WORD_W]) begin
        rem <= diff[scie_pkg::WORD_W-1:0];
        quot <= {quot[scie_pkg::WORD_W-2:0], 1'b1};
      end else begin
        rem <= trial[scie_pkg::WORD_W-1:0];
        quot <= {quot[scie_pkg::WORD_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* hdl/scie_back.sv */
// back end: register file, data memory, label table and execution sequencer
// depends on scie_pkg, scie_ram and scie_div
`timescale 1ns / 1ps

module scie_back #(
  parameter int DATA_WORDS = scie_pkg::DATA_WORDS_DEF,
  parameter int MAX_LABELS = scie_pkg::MAX_LABELS_DEF,
  parameter int NUM_REGS = scie_pkg::NUM_REGS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [scie_pkg::PLEN_W-1:0]         program_length,
  input  logic [scie_pkg::LCNT_W-1:0]         label_count,
  output logic                                clearing,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  scie_pkg::item_t                     q_item,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [scie_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tuser
);

  localparam int AW = $clog2(DATA_WORDS);
  localparam int LW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int LD = (MAX_LABELS > 1) ? MAX_LABELS : 2;
  localparam int RW = $clog2(NUM_REGS);
  localparam int W = scie_pkg::WORD_W;
  localparam logic [RW-1:0] SP_IDX = RW'(NUM_REGS - 2);
  localparam logic [RW-1:0] FL_IDX = RW'(NUM_REGS - 1);
  localparam logic [W-1:0] SP_RESET = W'(DATA_WORDS - 1);
  localparam logic [W-1:0] DW = W'(DATA_WORDS);

  scie_pkg::st_t state;
  scie_pkg::st_t state_next;

  scie_pkg::item_t it;
  logic [W-1:0] rf [NUM_REGS];
  logic [scie_pkg::PC_W-1:0] pc;
  logic running;
  logic [W-1:0] a_val;
  logic [W-1:0] b_val;
  logic [W-1:0] sp_val;
  logic [W-1:0] fl_val;
  logic [AW-1:0] clr_addr;

  logic [4:0] dst5;
  logic [4:0] src5;
  logic [RW-1:0] dst_i;
  logic [W-1:0] a_c;
  logic [W-1:0] b_c;
  logic [W-1:0] sp_c;
  logic [W-1:0] sp_inc_c;
  logic [W-1:0] sp_inc;
  logic [W-1:0] sp_dec;

  logic out_free;
  logic fire;
  logic div_go;
  logic div_done;
  logic [W-1:0] div_q;
  logic [W-1:0] div_r;

  logic dm_we_x;
  logic [AW-1:0] dm_waddr_x;
  logic [W-1:0] dm_wdata_x;
  logic dm_we;
  logic [AW-1:0] dm_waddr;
  logic [W-1:0] dm_wdata;
  logic [AW-1:0] dm_raddr;
  logic [W-1:0] dm_rdata;
  logic lt_we;
  logic [LW-1:0] lt_raddr;
  logic [scie_pkg::PC_W-1:0] lt_rdata;

  logic rf_we;
  logic [W-1:0] rf_wdata;
  logic sp_we;
  logic [W-1:0] sp_wdata;
  logic fl_we;
  logic [W-1:0] fl_wdata;
  logic [scie_pkg::PC_W-1:0] pc_next;
  logic running_next;
  logic pr_valid;
  logic [W-1:0] pr_value;
  logic stop;
  logic jumped;
  logic [scie_pkg::PC_W-1:0] target;
  logic [W-1:0] cmp_d;
  logic label_ok;

  assign dst5 = {1'b0, it.dst};
  assign src5 = {1'b0, it.src};
  assign dst_i = dst5[RW-1:0];
  assign a_c = it.has_dst ? rf[dst_i] : '0;
  assign b_c = it.has_src ? rf[src5[RW-1:0]] : it.imm;
  assign sp_c = rf[SP_IDX];
  assign sp_inc_c = sp_c + 32'd1;
  assign sp_inc = sp_val + 32'd1;
  assign sp_dec = sp_val - 32'd1;

  assign clearing = (state == scie_pkg::ST_CLEAR);
  assign q_ready = (state == scie_pkg::ST_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign fire = (state == scie_pkg::ST_EXEC && out_free && !div_go) ||
                (state == scie_pkg::ST_DWB && out_free);

  assign dm_raddr = (it.op == scie_pkg::OP_POP || it.op == scie_pkg::OP_RET) ?
                    sp_inc_c[AW-1:0] : b_c[AW-1:0];
  assign lt_raddr = it.imm[LW-1:0];
  assign label_ok = !it.imm[W-1] && (it.imm < W'(label_count)) &&
                    (it.imm < W'(MAX_LABELS));

  assign dm_we = clearing || dm_we_x;
  assign dm_waddr = clearing ? clr_addr : dm_waddr_x;
  assign dm_wdata = clearing ? '0 : dm_wdata_x;

  scie_ram #(.WIDTH(W), .DEPTH(DATA_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(dm_raddr), .rdata(dm_rdata)
  );

  scie_ram #(.WIDTH(scie_pkg::PC_W), .DEPTH(LD)) u_labels (
    .clk(clk), .we(lt_we), .waddr(lt_raddr), .wdata(it.tgt),
    .raddr(lt_raddr), .rdata(lt_rdata)
  );

  scie_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .dividend(a_val), .divisor(b_val),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  // execute step and divide result write back
  always_comb begin
    rf_we = 1'b0;
    rf_wdata = '0;
    sp_we = 1'b0;
    sp_wdata = '0;
    fl_we = 1'b0;
    fl_wdata = '0;
    dm_we_x = 1'b0;
    dm_waddr_x = '0;
    dm_wdata_x = '0;
    lt_we = 1'b0;
    div_go = 1'b0;
    pr_valid = 1'b0;
    pr_value = '0;
    stop = 1'b0;
    jumped = 1'b0;
    target = lt_rdata;
    cmp_d = a_val - b_val;
    if (state == scie_pkg::ST_EXEC && out_free) begin
      if (it.is_label) begin
        lt_we = label_ok || (!it.imm[W-1] && it.imm < W'(MAX_LABELS) &&
                             it.imm >= W'(label_count));
      end else if (!running || {1'b0, pc} >= program_length) begin
        stop = 1'b1;
      end else if (it.uses_label && !label_ok) begin
        stop = 1'b1;
      end else begin
        case (it.op)
          scie_pkg::OP_MOVE: begin
            rf_we = it.has_dst;
            rf_wdata = b_val;
          end
          scie_pkg::OP_LOAD: begin
            rf_we = it.has_dst && (b_val < DW);
            rf_wdata = dm_rdata;
          end
          scie_pkg::OP_STORE: begin
            dm_we_x = it.has_dst && (b_val < DW);
            dm_waddr_x = b_val[AW-1:0];
            dm_wdata_x = a_val;
          end
          scie_pkg::OP_ADD: begin
            rf_we = it.has_dst;
            rf_wdata = a_val + b_val;
          end
          scie_pkg::OP_SUB: begin
            rf_we = it.has_dst;
            rf_wdata = a_val - b_val;
          end
          scie_pkg::OP_MUL: begin
            rf_we = it.has_dst;
            rf_wdata = a_val * b_val;
          end
          scie_pkg::OP_DIV, scie_pkg::OP_MOD: begin
            div_go = it.has_dst && (b_val != '0);
          end
          scie_pkg::OP_AND: begin
            rf_we = it.has_dst;
            rf_wdata = a_val & b_val;
          end
          scie_pkg::OP_OR: begin
            rf_we = it.has_dst;
            rf_wdata = a_val | b_val;
          end
          scie_pkg::OP_XOR: begin
            rf_we = it.has_dst;
            rf_wdata = a_val ^ b_val;
          end
          scie_pkg::OP_NOT: begin
            rf_we = it.has_dst;
            rf_wdata = ~a_val;
          end
          scie_pkg::OP_SHL: begin
            rf_we = it.has_dst;
            rf_wdata = (b_val >= 32'd32) ? '0 : (a_val << b_val[4:0]);
          end
          scie_pkg::OP_SHR: begin
            rf_we = it.has_dst;
            rf_wdata = (b_val >= 32'd32) ? '0 : (a_val >> b_val[4:0]);
          end
          scie_pkg::OP_CMP: begin
            fl_we = 1'b1;
            if (cmp_d == '0) begin
              fl_wdata = scie_pkg::FLAGS_EQ;
            end else if (!cmp_d[W-1]) begin
              fl_wdata = scie_pkg::FLAGS_GT;
            end
          end
          scie_pkg::OP_JMP: jumped = 1'b1;
          scie_pkg::OP_JZ: jumped = (fl_val & scie_pkg::FLAGS_EQ) != '0;
          scie_pkg::OP_JNZ: jumped = (fl_val & scie_pkg::FLAGS_EQ) == '0;
          scie_pkg::OP_JG: jumped = (fl_val & scie_pkg::FLAGS_GT) != '0;
          scie_pkg::OP_JL: begin
            jumped = (fl_val & (scie_pkg::FLAGS_EQ | scie_pkg::FLAGS_GT)) == '0;
          end
          scie_pkg::OP_PUSH: begin
            if (sp_val != '0 && sp_val < DW) begin
              dm_we_x = 1'b1;
              dm_waddr_x = sp_val[AW-1:0];
              dm_wdata_x = it.has_dst ? a_val : it.imm;
              sp_we = 1'b1;
              sp_wdata = sp_dec;
            end
          end
          scie_pkg::OP_POP: begin
            if (it.has_dst && sp_val < SP_RESET) begin
              // popped word wins when it lands in the stack pointer
              sp_we = (dst_i != SP_IDX);
              sp_wdata = sp_inc;
              rf_we = 1'b1;
              rf_wdata = dm_rdata;
            end
          end
          scie_pkg::OP_CALL: begin
            if (sp_val != '0 && sp_val < DW) begin
              dm_we_x = 1'b1;
              dm_waddr_x = sp_val[AW-1:0];
              dm_wdata_x = W'(pc) + 32'd1;
              sp_we = 1'b1;
              sp_wdata = sp_dec;
              jumped = 1'b1;
            end
          end
          scie_pkg::OP_RET: begin
            if (sp_val < SP_RESET) begin
              sp_we = 1'b1;
              sp_wdata = sp_inc;
              target = dm_rdata[scie_pkg::PC_W-1:0];
              jumped = 1'b1;
            end
          end
          scie_pkg::OP_PRINT: begin
            pr_valid = 1'b1;
            pr_value = it.has_dst ? a_val : b_val;
          end
          default: ;
        endcase
      end
    end
    if (state == scie_pkg::ST_DWB && out_free) begin
      rf_we = 1'b1;
      rf_wdata = (it.op == scie_pkg::OP_MOD) ? div_r : div_q;
    end
  end

  always_comb begin
    running_next = running && !stop;
    if (state == scie_pkg::ST_EXEC && !it.is_label && !stop &&
        it.op == scie_pkg::OP_HALT) begin
      running_next = 1'b0;
    end
    if (it.is_label || stop) begin
      pc_next = pc;
    end else if (jumped) begin
      pc_next = target;
    end else begin
      pc_next = pc + 10'd1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      scie_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(DATA_WORDS - 1)) begin
          state_next = scie_pkg::ST_IDLE;
        end
      end
      scie_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = scie_pkg::ST_OPER;
        end
      end
      scie_pkg::ST_OPER: state_next = scie_pkg::ST_EXEC;
      scie_pkg::ST_EXEC: begin
        if (div_go) begin
          state_next = scie_pkg::ST_DIV;
        end else if (out_free) begin
          state_next = scie_pkg::ST_IDLE;
        end
      end
      scie_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = scie_pkg::ST_DWB;
        end
      end
      scie_pkg::ST_DWB: begin
        if (out_free) begin
          state_next = scie_pkg::ST_IDLE;
        end
      end
      default: state_next = scie_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scie_pkg::ST_CLEAR;
      clr_addr <= '0;
      pc <= '0;
      running <= 1'b1;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf[i] <= (RW'(i) == SP_IDX) ? SP_RESET : '0;
      end
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
      end
      m_axis_tvalid <= fire || (m_axis_tvalid && !m_axis_tready);
      if (fire) begin
        pc <= pc_next;
        running <= running_next;
      end
      if (sp_we) begin
        rf[SP_IDX] <= sp_wdata;
      end
      if (fl_we) begin
        rf[FL_IDX] <= fl_wdata;
      end
      if (rf_we) begin
        rf[dst_i] <= rf_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == scie_pkg::ST_IDLE && q_valid) begin
      it <= q_item;
    end
    if (state == scie_pkg::ST_OPER) begin
      a_val <= a_c;
      b_val <= b_c;
      sp_val <= sp_c;
      fl_val <= rf[FL_IDX];
    end
    if (fire) begin
      m_axis_tdata <= {5'd0, pr_value, !running_next, pc_next};
      m_axis_tuser <= pr_valid;
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(q_valid && q_ready))
    else $error("request taken during memory clear");

  a_div_flow: assert property (@(posedge clk) disable iff (rst)
    state == scie_pkg::ST_DIV |=>
      (state == scie_pkg::ST_DIV || state == scie_pkg::ST_DWB))
    else $error("divide state left early");

  a_dm_write_src: assert property (@(posedge clk) disable iff (rst)
    dm_we_x |-> state == scie_pkg::ST_EXEC)
    else $error("data memory written outside execute");

  a_div_result: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == scie_pkg::ST_DIV)
    else $error("divider finished outside divide state");

endmodule

/* hdl/small_cpu_instruction_execute.sv */
// top level of the small cpu instruction execute block
// depends on scie_pkg, scie_front, scie_queue, scie_back
//
// usage:
//   s_axis carries one request per transfer: tuser high writes a label
//   entry, tuser low executes the instruction read at the last next_pc.
//   m_axis returns one result per request, in order.
//   cfg writes program_length (index 0) and label_count (index 1); cfg_ready
//   is always high; the user must make writes only while the block is idle (not enforced by the block).
// request flow:
//   a request passes the queue, is taken by the idle back end, has its
//   operands read and is executed; div and mod with a nonzero divisor and
//   a destination also use the bit-serial divider. One request is executed
//   at a time; the two entry queue keeps taking requests.
// reset:
//   rst clears the counter, sets the run flag and the stack pointer, then a
//   clearing pass writes zero to every data memory word, during which
//   s_axis_tready stays low.
// stall:
//   a held result keeps the back end waiting; the queue fills and then
//   s_axis_tready drops.
`timescale 1ns / 1ps

module small_cpu_instruction_execute #(
  parameter int DATA_WORDS = scie_pkg::DATA_WORDS_DEF,
  parameter int MAX_LABELS = scie_pkg::MAX_LABELS_DEF,
  parameter int NUM_REGS = scie_pkg::NUM_REGS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // opcode, dest_reg, src_reg, immediate, label_target
  input  logic [scie_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // next_pc, halted, print_value
  output logic [scie_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // print_valid
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scie_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scie_pkg::PLEN_W-1:0]         cfg_data
);

  logic [scie_pkg::PLEN_W-1:0] program_length;
  logic [scie_pkg::LCNT_W-1:0] label_count;
  logic clearing;
  logic fq_valid;
  logic fq_ready;
  scie_pkg::item_t fq_item;
  logic qb_valid;
  logic qb_ready;
  scie_pkg::item_t qb_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
      label_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        scie_pkg::CFG_PROGRAM_LENGTH: program_length <= cfg_data;
        scie_pkg::CFG_LABEL_COUNT: label_count <= cfg_data[scie_pkg::LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  scie_front #(.NUM_REGS(NUM_REGS)) u_front (
    .blocked(clearing),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
  );

  scie_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(fq_valid), .in_ready(fq_ready), .in_item(fq_item),
    .out_valid(qb_valid), .out_ready(qb_ready), .out_item(qb_item)
  );

  scie_back #(
    .DATA_WORDS(DATA_WORDS), .MAX_LABELS(MAX_LABELS), .NUM_REGS(NUM_REGS)
  ) u_back (
    .clk(clk), .rst(rst),
    .program_length(program_length), .label_count(label_count),
    .clearing(clearing),
    .q_valid(qb_valid), .q_ready(qb_ready), .q_item(qb_item),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

endmodule

/* verif/scie_checker.sv */
// result checker for the small cpu instruction execute block
// watches request, result and register channels, predicts each result; needs scie_pkg
`timescale 1ns / 1ps

module scie_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [scie_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [scie_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             m_axis_tuser,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [scie_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scie_pkg::PLEN_W-1:0]      cfg_data,
  output int                               errors,
  output int                               pending
);

  localparam int NR = scie_pkg::NUM_REGS_DEF;
  localparam int DW = scie_pkg::DATA_WORDS_DEF;
  localparam int ML = scie_pkg::MAX_LABELS_DEF;
  localparam int PW = scie_pkg::PC_W;
  localparam int WW = scie_pkg::WORD_W;
  localparam int SP = NR - 2;
  localparam int FL = NR - 1;

  typedef struct {
    logic [PW-1:0] next_pc;
    logic          halted;
    logic          print_valid;
    logic [WW-1:0] print_value;
  } outcome_t;

  outcome_t outcomes_q[$];

  logic [scie_pkg::PLEN_W-1:0] prog_len;
  logic [scie_pkg::LCNT_W-1:0] label_cnt;
  logic [PW-1:0]   pc;
  logic            running;
  logic [WW-1:0]   regs[NR];
  logic [WW-1:0]   mem[DW];
  logic [PW-1:0]   labels[ML];

  function automatic logic [WW-1:0] operand(logic [3:0] s, logic [WW-1:0] imm);
    return (s < NR) ? regs[s] : imm;
  endfunction

  function automatic outcome_t execute_item(logic oper,
                                            logic [scie_pkg::IN_TDATA_W-1:0] d);
    outcome_t o;
    logic [4:0] opc;
    logic [3:0] dst, src;
    logic [WW-1:0] imm, v, sp, a, diff;
    logic [PW-1:0] tgt, dest_pc;
    logic has_dst, jumped, stop;
    opc = d[4:0];
    dst = d[8:5];
    src = d[12:9];
    imm = d[44:13];
    tgt = d[54:45];
    has_dst = dst < NR;
    jumped = 0;
    stop = 0;
    dest_pc = '0;
    o.print_valid = 0;
    o.print_value = '0;
    if (oper) begin
      if (!imm[31] && imm < ML) labels[imm] = tgt;
    end else if (!running || pc >= prog_len) begin
      running = 0;
    end else begin
      if ((opc >= scie_pkg::OP_JMP && opc <= scie_pkg::OP_JL) ||
          opc == scie_pkg::OP_CALL) begin
        if (!imm[31] && imm < label_cnt && imm < ML) dest_pc = labels[imm];
        else begin
          running = 0;
          stop = 1;
        end
      end
      if (!stop) begin
        sp = regs[SP];
        v = operand(src, imm);
        case (opc)
          scie_pkg::OP_MOVE: if (has_dst) regs[dst] = v;
          scie_pkg::OP_LOAD: if (has_dst && v < DW) regs[dst] = mem[v];
          scie_pkg::OP_STORE: if (has_dst && v < DW) mem[v] = regs[dst];
          scie_pkg::OP_ADD: if (has_dst) regs[dst] = regs[dst] + v;
          scie_pkg::OP_SUB: if (has_dst) regs[dst] = regs[dst] - v;
          scie_pkg::OP_MUL: if (has_dst) regs[dst] = regs[dst] * v;
          scie_pkg::OP_DIV: if (has_dst && v != 0) regs[dst] = regs[dst] / v;
          scie_pkg::OP_MOD: if (has_dst && v != 0) regs[dst] = regs[dst] % v;
          scie_pkg::OP_AND: if (has_dst) regs[dst] = regs[dst] & v;
          scie_pkg::OP_OR: if (has_dst) regs[dst] = regs[dst] | v;
          scie_pkg::OP_XOR: if (has_dst) regs[dst] = regs[dst] ^ v;
          scie_pkg::OP_NOT: if (has_dst) regs[dst] = ~regs[dst];
          scie_pkg::OP_SHL: if (has_dst) regs[dst] = (v >= 32) ? '0 : regs[dst] << v[4:0];
          scie_pkg::OP_SHR: if (has_dst) regs[dst] = (v >= 32) ? '0 : regs[dst] >> v[4:0];
          scie_pkg::OP_CMP: begin
            a = has_dst ? regs[dst] : '0;
            diff = a - v;
            if (diff == 0) regs[FL] = scie_pkg::FLAGS_EQ;
            else if (!diff[31]) regs[FL] = scie_pkg::FLAGS_GT;
            else regs[FL] = '0;
          end
          scie_pkg::OP_JMP: jumped = 1;
          scie_pkg::OP_JZ: jumped = (regs[FL] & scie_pkg::FLAGS_EQ) != 0;
          scie_pkg::OP_JNZ: jumped = (regs[FL] & scie_pkg::FLAGS_EQ) == 0;
          scie_pkg::OP_JG: jumped = (regs[FL] & scie_pkg::FLAGS_GT) != 0;
          scie_pkg::OP_JL:
            jumped = (regs[FL] & (scie_pkg::FLAGS_EQ | scie_pkg::FLAGS_GT)) == 0;
          scie_pkg::OP_PUSH: if (sp > 0 && sp < DW) begin
            mem[sp] = has_dst ? regs[dst] : imm;
            regs[SP] = sp - 1;
          end
          scie_pkg::OP_POP: if (has_dst && sp < DW - 1) begin
            regs[SP] = sp + 1;
            regs[dst] = mem[sp + 1];
          end
          scie_pkg::OP_CALL: if (sp > 0 && sp < DW) begin
            mem[sp] = 32'(pc) + 1;
            regs[SP] = sp - 1;
            jumped = 1;
          end
          scie_pkg::OP_RET: if (sp < DW - 1) begin
            regs[SP] = sp + 1;
            dest_pc = mem[sp + 1][PW-1:0];
            jumped = 1;
          end
          scie_pkg::OP_PRINT: begin
            o.print_valid = 1;
            o.print_value = has_dst ? regs[dst] : v;
          end
          scie_pkg::OP_HALT: running = 0;
          default: ;
        endcase
        pc = jumped ? dest_pc : pc + 1'b1;
      end
    end
    o.next_pc = pc;
    o.halted = !running;
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t e;
    int bad;
    bad = 0;
    if (rst) begin
      prog_len <= '0;
      label_cnt <= '0;
      pc = '0;
      running = 1;
      foreach (regs[i]) regs[i] = '0;
      regs[SP] = DW - 1;
      foreach (mem[i]) mem[i] = '0;
      foreach (labels[i]) labels[i] = '0;
      outcomes_q.delete();
      errors <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcomes_q.size() == 0) begin
          $error("result with no request outstanding: %h", m_axis_tdata);
          bad++;
        end else begin
          e = outcomes_q.pop_front();
          if (m_axis_tdata[9:0] !== e.next_pc) begin
            $error("next_pc expected %0d actual %0d", e.next_pc, m_axis_tdata[9:0]);
            bad++;
          end
          if (m_axis_tdata[10] !== e.halted) begin
            $error("halted expected %0d actual %0d", e.halted, m_axis_tdata[10]);
            bad++;
          end
          if (m_axis_tuser !== e.print_valid) begin
            $error("print_valid expected %0d actual %0d", e.print_valid, m_axis_tuser);
            bad++;
          end
          if (m_axis_tdata[42:11] !== e.print_value) begin
            $error("print_value expected %h actual %h", e.print_value, m_axis_tdata[42:11]);
            bad++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        outcomes_q.push_back(execute_item(s_axis_tuser, s_axis_tdata));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == scie_pkg::CFG_PROGRAM_LENGTH) prog_len <= cfg_data;
        else if (cfg_index == scie_pkg::CFG_LABEL_COUNT)
          label_cnt <= cfg_data[scie_pkg::LCNT_W-1:0];
      end
      errors <= errors + bad;
    end
    pending <= outcomes_q.size();
  end

endmodule

/* verif/tb_small_cpu_instruction_execute.sv */
// testbench top for the small cpu instruction execute block
// drives requests and register writes, gives the verdict; needs scie_pkg, scie_checker, small_cpu_instruction_execute
`timescale 1ns / 1ps

module tb_small_cpu_instruction_execute;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [scie_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [scie_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [scie_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [scie_pkg::PLEN_W-1:0] cfg_data;
  int errors, pending, quiet_cycles;
  bit calm, hold_req;
  logic [scie_pkg::LCNT_W-1:0] live_labels;

  small_cpu_instruction_execute dut (.*);

  scie_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        m_axis_tready <= 0;
      end else
        m_axis_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 6000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [scie_pkg::CFG_IDX_W-1:0] idx,
                           logic [scie_pkg::PLEN_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic send_req(logic oper, logic [4:0] opc, logic [3:0] dst, logic [3:0] src,
                          logic [31:0] imm, logic [9:0] tgt);
    s_axis_tvalid <= 1;
    s_axis_tuser <= oper;
    s_axis_tdata <= {1'b0, tgt, imm, src, dst, opc};
    do @(posedge clk); while (!s_axis_tready);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic exec(scie_pkg::op_t op, logic [3:0] dst, logic [3:0] src,
                      logic [31:0] imm);
    send_req(1'b0, op, dst, src, imm, 10'($urandom));
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [3:0] pick_reg;
    return ($urandom_range(0, 9) < 9) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
  endfunction

  task automatic random_req;
    logic [4:0] opc;
    logic [31:0] imm;
    if ($urandom_range(0, 99) < 4) begin
      imm = $urandom_range(0, 1) ? 32'($urandom_range(0, 127)) : $urandom;
      send_req(1'b1, 5'($urandom), 4'($urandom), 4'($urandom), imm, 10'($urandom));
      return;
    end
    if ($urandom_range(0, 99) < 3) opc = 5'($urandom_range(27, 31));
    else begin
      opc = 5'($urandom_range(0, 25));
    end
    case ($urandom_range(0, 3))
      0: imm = $urandom;
      1: imm = 32'($urandom_range(0, 40));
      2: imm = 32'($urandom_range(0, 1100));
      default: imm = {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
    endcase
    if ((opc >= scie_pkg::OP_JMP && opc <= scie_pkg::OP_JL) || opc == scie_pkg::OP_CALL)
      imm = 32'($urandom_range(0, live_labels - 1));
    send_req(1'b0, opc, pick_reg(), pick_reg(), imm, 10'($urandom));
  endtask

  initial begin
    rst = 1;
    calm = 0;
    hold_req = 0;
    s_axis_tvalid = 0;
    s_axis_tuser = 0;
    s_axis_tdata = '0;
    cfg_valid = 0;
    cfg_index = scie_pkg::CFG_PROGRAM_LENGTH;
    cfg_data = '0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    write_reg(scie_pkg::CFG_PROGRAM_LENGTH, 11'd1024);
    write_reg(scie_pkg::CFG_LABEL_COUNT, 11'd64);
    live_labels = 7'd64;

    // fill every label entry, plus indexes that are ignored
    for (int i = 0; i < scie_pkg::MAX_LABELS_DEF; i++)
      send_req(1'b1, scie_pkg::OP_NOP, 4'd0, 4'd0, 32'(i), 10'($urandom));
    send_req(1'b1, scie_pkg::OP_NOP, 4'd0, 4'd0, 32'd64, 10'h3ff);
    send_req(1'b1, scie_pkg::OP_NOP, 4'd15, 4'd15, 32'hffff_ffff, 10'h3ff);

    // directed
    exec(scie_pkg::OP_MOVE, 4'd0, 4'd8, 32'h7fff_ffff);
    exec(scie_pkg::OP_MOVE, 4'd1, 4'd8, 32'h8000_0000);
    exec(scie_pkg::OP_ADD, 4'd0, 4'd1, 32'd0);
    exec(scie_pkg::OP_SUB, 4'd1, 4'd8, 32'hffff_ffff);
    exec(scie_pkg::OP_MUL, 4'd0, 4'd0, 32'd0);
    exec(scie_pkg::OP_DIV, 4'd1, 4'd8, 32'd0);
    exec(scie_pkg::OP_DIV, 4'd1, 4'd8, 32'd7);
    exec(scie_pkg::OP_MOD, 4'd0, 4'd1, 32'd0);
    exec(scie_pkg::OP_AND, 4'd0, 4'd8, 32'h0f0f_0f0f);
    exec(scie_pkg::OP_OR, 4'd2, 4'd8, 32'hffff_ffff);
    exec(scie_pkg::OP_XOR, 4'd2, 4'd0, 32'd0);
    exec(scie_pkg::OP_NOT, 4'd3, 4'd8, 32'd0);
    exec(scie_pkg::OP_SHL, 4'd3, 4'd8, 32'd31);
    exec(scie_pkg::OP_SHR, 4'd2, 4'd8, 32'd32);
    exec(scie_pkg::OP_STORE, 4'd3, 4'd8, 32'd1023);
    exec(scie_pkg::OP_LOAD, 4'd4, 4'd8, 32'd1023);
    exec(scie_pkg::OP_LOAD, 4'd4, 4'd8, 32'd1024);
    exec(scie_pkg::OP_CMP, 4'd4, 4'd3, 32'd0);
    exec(scie_pkg::OP_JZ, 4'd0, 4'd0, 32'd63);
    exec(scie_pkg::OP_CMP, 4'd8, 4'd8, 32'hffff_ffff);
    exec(scie_pkg::OP_JG, 4'd0, 4'd0, 32'd0);
    exec(scie_pkg::OP_JNZ, 4'd0, 4'd0, 32'd5);
    exec(scie_pkg::OP_JL, 4'd0, 4'd0, 32'd5);
    exec(scie_pkg::OP_CALL, 4'd0, 4'd0, 32'd9);
    exec(scie_pkg::OP_PUSH, 4'd8, 4'd8, 32'h8000_0001);
    exec(scie_pkg::OP_POP, 4'd5, 4'd8, 32'd0);
    exec(scie_pkg::OP_RET, 4'd0, 4'd0, 32'd0);
    exec(scie_pkg::OP_PRINT, 4'd8, 4'd8, 32'hdead_beef);
    exec(scie_pkg::OP_PRINT, 4'd8, 4'd0, 32'd0);
    exec(scie_pkg::OP_PRINT, 4'd3, 4'd8, 32'd0);
    send_req(1'b0, 5'd31, 4'd15, 4'd15, 32'hffff_ffff, 10'h3ff);
    drain();

    // random phases with different label counts
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: live_labels = 7'd64;
        1: live_labels = 7'd1;
        default: live_labels = scie_pkg::LCNT_W'($urandom_range(2, 63));
      endcase
      write_reg(scie_pkg::CFG_LABEL_COUNT, 11'(live_labels));
      if (ph == 2) calm = 1;
      for (int n = 0; n < 215; n++) begin
        if (ph == 1 && n == 50) hold_req = 1;
        random_req();
      end
      drain();
    end

    // stopping the machine is permanent, so it comes last
    exec(scie_pkg::OP_HALT, 4'd0, 4'd0, 32'd0);
    exec(scie_pkg::OP_JMP, 4'd0, 4'd0, 32'hffff_ffff);
    drain();
    write_reg(scie_pkg::CFG_PROGRAM_LENGTH, 11'd0);
    write_reg(scie_pkg::CFG_LABEL_COUNT, 11'd0);
    exec(scie_pkg::OP_MOVE, 4'd0, 4'd8, 32'd1);
    exec(scie_pkg::OP_PRINT, 4'd0, 4'd8, 32'd1);
    drain();

    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
